/* hdl/satt_pkg.sv */
// Shared types, codes and constants for the station admission timeout table.
// No dependencies; imported by every module of the block.
`default_nettype none

package satt_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int ADDR_W           = 48;
   localparam int TICKS_W          = 16;
   localparam int AID_W            = 11;
   localparam int RSP_CNT_W        = 5;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 16;

   // request opcodes
   localparam logic [1:0] OP_JOIN  = 2'd0;
   localparam logic [1:0] OP_LEAVE = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // result actions
   localparam logic [2:0] ACT_STATUS   = 3'd0;
   localparam logic [2:0] ACT_ADMIT    = 3'd1;
   localparam logic [2:0] ACT_REJECT   = 3'd2;
   localparam logic [2:0] ACT_TIMEOUT  = 3'd3;
   localparam logic [2:0] ACT_OVERFLOW = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_RSSI_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_CLI  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LIFETIME = 2'd2;

   // register reset values
   localparam logic signed [7:0] RST_RSSI_THR = -8'sd70;
   localparam logic [3:0]        RST_MAX_CLI  = 4'd15;
   localparam logic [15:0]       RST_LIFETIME = 16'd60000;

   typedef struct packed {
      logic [1:0]        op;
      logic [ADDR_W-1:0] station_addr;
      logic signed [7:0] signal_level;
      logic [AID_W-1:0]  assoc_id;
   } req_type;

   typedef struct packed {
      logic [2:0]           action;
      logic [ADDR_W-1:0]    out_addr;
      logic [AID_W-1:0]     out_assoc_id;
      logic [RSP_CNT_W-1:0] client_count;
      logic                 full_res;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic signed [7:0]  rssi_join_threshold;
      logic [3:0]         max_clients;
      logic [TICKS_W-1:0] client_lifetime;
   } cfg_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [TICKS_W-1:0] ticks;
   } entry_type;

endpackage

`default_nettype wire

/* hdl/satt_mem.sv */
// Station entry store: one write port, one read port with registered data.
// Depends on satt_pkg for the entry type.
`default_nettype none

module satt_mem import satt_pkg::*; #(
   parameter int  DEPTH = DEFAULT_CAPACITY,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output      entry_type        rd_data
);

   entry_type store [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/satt_walk.sv */
// Request sequencer: walks the store one entry per cycle unless stalled, via a
// shared compare/decrement unit; owns the result register. Depends on satt_pkg.
`default_nettype none

module satt_walk import satt_pkg::*; #(
   parameter int  CAPACITY = DEFAULT_CAPACITY,
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire req_type          req_data,
   output      logic             rsp_valid,
   input  wire logic             rsp_ready,
   output      rsp_type          rsp_data,
   output      logic             mem_we,
   output      logic [IDX_W-1:0] mem_waddr,
   output      entry_type        mem_wdata,
   output      logic             mem_re,
   output      logic [IDX_W-1:0] mem_raddr,
   input  wire entry_type        mem_rdata
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             full_ff, full_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             have_ff, have_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             out_free;
   logic [CNT_W-1:0] proc_idx;
   logic [CNT_W-1:0] shift_idx;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc_idx  = rd_idx_ff - CNT_W'(1);
   assign shift_idx = rd_idx_ff - CNT_W'(2);
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      logic             stall;
      logic [CNT_W-1:0] cnt_new;
      logic             full_new;
      logic [2:0]       act;
      logic [AID_W-1:0] aid;

      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      full_in      = full_ff;
      found_in     = found_ff;
      rd_idx_in    = rd_idx_ff;
      have_in      = have_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_waddr    = proc_idx[IDX_W-1:0];
      mem_wdata    = mem_rdata;
      mem_re       = 1'b0;
      mem_raddr    = rd_idx_ff[IDX_W-1:0];
      stall        = 1'b0;
      cnt_new      = count_ff;
      full_new     = full_ff;
      act          = ACT_STATUS;
      aid          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               rd_idx_in = '0;
               have_in   = 1'b0;
               found_in  = 1'b0;
               if (req_data.op == OP_LEAVE || req_data.op == OP_TICK) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_WALK: begin
            stall = have_ff && (req_ff.op == OP_TICK) &&
                    (mem_rdata.ticks == TICKS_W'(1)) && !out_free;
            if (!stall) begin
               if (have_ff) begin
                  if (req_ff.op == OP_TICK) begin
                     if (mem_rdata.ticks != '0) begin
                        mem_we          = 1'b1;
                        mem_waddr       = proc_idx[IDX_W-1:0];
                        mem_wdata.addr  = mem_rdata.addr;
                        mem_wdata.ticks = mem_rdata.ticks - TICKS_W'(1);
                     end
                     if (mem_rdata.ticks == TICKS_W'(1)) begin
                        rsp_valid_in        = 1'b1;
                        rsp_in.action       = ACT_TIMEOUT;
                        rsp_in.out_addr     = mem_rdata.addr;
                        rsp_in.out_assoc_id = '0;
                        rsp_in.client_count = RSP_CNT_W'(count_ff);
                        rsp_in.full_res     = full_ff;
                        rsp_in.last         = 1'b0;
                     end
                  end else begin
                     // leave: close the gap behind the first match
                     if (found_ff) begin
                        mem_we    = 1'b1;
                        mem_waddr = shift_idx[IDX_W-1:0];
                        mem_wdata = mem_rdata;
                     end else if (mem_rdata.addr == req_ff.station_addr) begin
                        found_in = 1'b1;
                     end
                  end
               end
               if (rd_idx_ff < count_ff) begin
                  mem_re    = 1'b1;
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  have_in   = 1'b1;
               end else begin
                  have_in = 1'b0;
                  if (!have_ff) begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               case (req_ff.op)
                  OP_JOIN: begin
                     if ($signed(req_ff.signal_level) <=
                         $signed(cfg.rssi_join_threshold)) begin
                        act = ACT_REJECT;
                        aid = req_ff.assoc_id;
                     end else if (count_ff == CNT_W'(CAPACITY)) begin
                        act = ACT_OVERFLOW;
                        aid = req_ff.assoc_id;
                     end else begin
                        act             = ACT_ADMIT;
                        mem_we          = 1'b1;
                        mem_waddr       = count_ff[IDX_W-1:0];
                        mem_wdata.addr  = req_ff.station_addr;
                        mem_wdata.ticks = cfg.client_lifetime;
                        cnt_new         = count_ff + CNT_W'(1);
                     end
                     full_new = full_ff ||
                                (CMP_W'(cnt_new) >= CMP_W'(cfg.max_clients));
                  end
                  OP_LEAVE: begin
                     cnt_new  = found_ff ? count_ff - CNT_W'(1) : count_ff;
                     full_new = (CMP_W'(cnt_new) < CMP_W'(cfg.max_clients)) ?
                                1'b0 : full_ff;
                  end
                  default: begin
                     cnt_new  = count_ff;
                     full_new = full_ff;
                  end
               endcase
               count_in            = cnt_new;
               full_in             = full_new;
               rsp_valid_in        = 1'b1;
               rsp_in.action       = act;
               rsp_in.out_addr     = (act == ACT_STATUS) ? '0 : req_ff.station_addr;
               rsp_in.out_assoc_id = aid;
               rsp_in.client_count = RSP_CNT_W'(cnt_new);
               rsp_in.full_res     = full_new;
               rsp_in.last         = 1'b1;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         full_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rd_idx_ff    <= '0;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         full_ff      <= full_in;
         found_ff     <= found_in;
         rd_idx_ff    <= rd_idx_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

/* hdl/station_admission_timeout_table.sv */
// Top level of the station admission timeout table: configuration registers,
// entry store and request sequencer. Depends on satt_pkg, satt_mem, satt_walk.
//
//   channel   ports                              payload
//   request   req_valid / req_ready              req_data  (req_type)
//   result    rsp_valid / rsp_ready              rsp_data  (rsp_type)
//   config    csr_we, csr_index                  csr_wdata (16 bit, no handshake)
//
// Join and any opcode other than leave or tick: accept, then decide and write the result.
// Leave and tick walk the table through the single store read port, one entry a
// cycle unless a tick stalls; the closing result is registered once the walk ends
// and the result register is free.
// A tick holds its walk while a timeout result cannot enter the result register.
// Reset clears the count, the full flag and the walk state and loads the register
// reset values; entries need no clearing since only entries below the count are ever read.
`default_nettype none

module station_admission_timeout_table import satt_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire req_type               req_data,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      rsp_type               rsp_data,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   cfg_type          cfg_ff, cfg_in;

   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr;
   entry_type        mem_wdata;
   logic             mem_re;
   logic [IDX_W-1:0] mem_raddr;
   entry_type        mem_rdata;

   // Decode register writes; writes beyond the list drop.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RSSI_THR: cfg_in.rssi_join_threshold = csr_wdata[7:0];
            REG_MAX_CLI:  cfg_in.max_clients         = csr_wdata[3:0];
            REG_LIFETIME: cfg_in.client_lifetime     = csr_wdata[TICKS_W-1:0];
            default:      cfg_in                     = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rssi_join_threshold <= RST_RSSI_THR;
         cfg_ff.max_clients         <= RST_MAX_CLI;
         cfg_ff.client_lifetime     <= RST_LIFETIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Entry store: address and remaining ticks per admitted station.
   satt_mem #(
      .DEPTH (CAPACITY)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Sequencer: one request at a time, holds the result register.
   satt_walk #(
      .CAPACITY (CAPACITY)
   ) u_walk (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

endmodule

`default_nettype wire
